@@ src/annotation_container_validator_defines.svh @@
// assertion macros shared by the design files
`ifndef ANNOTATION_CONTAINER_VALIDATOR_DEFINES_SVH
`define ANNOTATION_CONTAINER_VALIDATOR_DEFINES_SVH
`define ACV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ACV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ src/acv_pkg.sv @@
// ----------------------------------------------------------------------------
// acv_pkg
// types and constants shared by the annotation container validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package acv_pkg;
  localparam int unsigned MaxEntries = 100000;
  localparam logic [23:0] MaxFileBytes = 24'd8388608;
  localparam logic [4:0] ExtLimit = 5'd16;

  typedef enum logic [2:0] {
    FLT_NONE = 3'd0, FLT_OVERSIZE = 3'd1, FLT_MAGIC = 3'd2, FLT_COUNT = 3'd3,
    FLT_INDEX = 3'd4, FLT_LENGTH = 3'd5, FLT_TRUNC = 3'd6, FLT_VALUE = 3'd7
  } fault_t;

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0, PH_COUNT = 3'd1, PH_INDEX = 3'd2, PH_LENGTH = 3'd3,
    PH_VALUE = 3'd4, PH_DONE = 3'd5
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // byte accepted
    logic walk_start; // begin backward walk of buffered value
    logic walk_step;  // consume one buffered byte
    logic walk_pass;  // walk finished without fault
    logic walk_fail;  // walk fault
    logic clear;      // verdict issued
  } acv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic value_full; // last value byte arrives with this beat
    logic walk_done;  // walk finished (pass or fail) this cycle
    logic walk_ok;
  } acv_sts_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction
endpackage
`default_nettype wire

@@ src/acv_datapath.sv @@
// ----------------------------------------------------------------------------
// acv_datapath
// field assembly, header checks, value buffer and backward tree walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "annotation_container_validator_defines.svh"
module acv_datapath
  import acv_pkg::*;
#(
  parameter int unsigned VALUE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire acv_cmd_t    cmd,
  output acv_sts_t         sts,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] triangle_limit,
  input  wire logic [7:0]  max_state,
  output logic             valid_res,
  output logic [2:0]       fault,
  output logic [16:0]      entry_total
);
  localparam int AW = $clog2(VALUE_BYTES);
  localparam int LW = $clog2(VALUE_BYTES + 1);
  localparam int PW = $clog2(VALUE_BYTES * 4 + 1) + 1;

  phase_t      phase;
  logic [23:0] field_shift;
  logic [1:0]  byte_pos;
  logic [23:0] bytes_seen;
  logic [16:0] entries_declared, entries_done;
  logic [31:0] prior_index;
  logic        have_prior, count_ok;
  logic [LW-1:0] value_length, wr_cnt, cur;
  logic [2:0]  first_fault;
  logic [7:0]  mem [VALUE_BYTES];
  logic [7:0]  rd_data;
  logic        rd_valid;
  logic [PW-1:0] pending;
  logic        in_ext;
  logic [4:0]  ext_cnt;
  logic        walking;

  logic [31:0] word;
  logic [23:0] seen_next;
  logic [2:0]  flt, flt_next;
  logic [7:0]  magic_exp;
  logic        over;

  assign word = {field_shift, data_byte};
  assign seen_next = (bytes_seen <= MaxFileBytes) ? bytes_seen + 24'd1 : bytes_seen;
  assign over = seen_next > MaxFileBytes;

  always_comb begin
    unique case (byte_pos)
      2'd0: magic_exp = 8'h44;
      2'd1: magic_exp = 8'h4F;
      2'd2: magic_exp = 8'h41;
      default: magic_exp = 8'h31;
    endcase
  end

  always_comb begin
    flt = FLT_NONE;
    if (over) flt = FLT_OVERSIZE;
    else if (phase == PH_MAGIC && data_byte != magic_exp) flt = FLT_MAGIC;
    else if (phase == PH_DONE) flt = FLT_TRUNC;
    else if (byte_pos == 2'd3 && phase == PH_COUNT && word > MaxEntries) flt = FLT_COUNT;
    else if (byte_pos == 2'd3 && phase == PH_INDEX &&
             (word >= triangle_limit || (have_prior && word <= prior_index)))
      flt = FLT_INDEX;
    else if (byte_pos == 2'd3 && phase == PH_LENGTH &&
             (word == 32'd0 || word > VALUE_BYTES))
      flt = FLT_LENGTH;
    flt_next = (first_fault != FLT_NONE) ? first_fault : flt;
  end

  assign sts.value_full = (first_fault == FLT_NONE) && !over && phase == PH_VALUE &&
                          (wr_cnt + LW'(1) >= value_length);

  // walk step evaluation on registered byte
  logic [4:0] code;
  logic       w_fail, w_pass;
  logic [PW-1:0] pend_n;
  logic [8:0] st;
  always_comb begin
    code = hex_digit(rd_data);
    w_fail = 1'b0;
    w_pass = 1'b0;
    pend_n = pending;
    st = 9'd0;
    if (rd_valid) begin
      if (code[4]) w_fail = 1'b1;
      else if (in_ext) begin
        if (code[3:0] == 4'hF) begin
          if (ext_cnt + 5'd1 > ExtLimit) w_fail = 1'b1;
          else if (cur == '0) w_fail = 1'b1;
        end else begin
          st = 9'(code[3:0]) + 9'(ext_cnt) * 9'd15 + 9'd3;
          if (st > 9'(max_state)) w_fail = 1'b1;
          else if (pending == '0) w_pass = (cur == '0);
          else if (cur == '0) w_fail = 1'b1;
          w_fail = w_fail | (pending == '0 && cur != '0 && st <= 9'(max_state));
        end
      end else begin
        pend_n = pending - PW'(1);
        if (code[1:0] != 2'b00) begin
          pend_n = pend_n + PW'(code[1:0]) + PW'(1);
          if (pend_n > PW'(VALUE_BYTES * 4)) w_fail = 1'b1;
          else if (cur == '0) w_fail = 1'b1;
        end else if (code[3:2] == 2'b11) begin
          if (cur == '0) w_fail = 1'b1;
        end else begin
          if (9'(code[3:2]) > 9'(max_state)) w_fail = 1'b1;
          else if (pend_n == '0) begin
            if (cur == '0) w_pass = 1'b1; else w_fail = 1'b1;
          end else if (cur == '0) w_fail = 1'b1;
        end
      end
    end
  end
  assign sts.walk_done = w_fail | w_pass;
  assign sts.walk_ok = w_pass;

  always_ff @(posedge clk) begin
    if (cmd.take && phase == PH_VALUE && first_fault == FLT_NONE && !over)
      mem[wr_cnt[AW-1:0]] <= data_byte;
    rd_data <= mem[cur[AW-1:0] - AW'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase <= PH_MAGIC; field_shift <= '0; byte_pos <= '0; bytes_seen <= '0;
      entries_declared <= '0; entries_done <= '0; prior_index <= '0;
      have_prior <= 1'b0; count_ok <= 1'b0; value_length <= '0; wr_cnt <= '0;
      cur <= '0; first_fault <= FLT_NONE; rd_valid <= 1'b0; pending <= '0;
      in_ext <= 1'b0; ext_cnt <= '0; walking <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      if (cmd.take) begin
        bytes_seen <= seen_next;
        first_fault <= flt_next;
        if (first_fault == FLT_NONE && flt == FLT_NONE) begin
          if (phase == PH_MAGIC) begin
            byte_pos <= byte_pos + 2'd1;
            if (byte_pos == 2'd3) phase <= PH_COUNT;
          end else if (phase == PH_VALUE) begin
            wr_cnt <= wr_cnt + LW'(1);
          end else begin
            field_shift <= word[23:0];
            byte_pos <= byte_pos + 2'd1;
            if (byte_pos == 2'd3) begin
              field_shift <= '0;
              unique case (phase)
                PH_COUNT: begin
                  entries_declared <= word[16:0];
                  count_ok <= 1'b1;
                  phase <= (word == 32'd0) ? PH_DONE : PH_INDEX;
                end
                PH_INDEX: begin
                  prior_index <= word; have_prior <= 1'b1; phase <= PH_LENGTH;
                end
                default: begin
                  value_length <= word[LW-1:0]; wr_cnt <= '0; phase <= PH_VALUE;
                end
              endcase
            end
          end
        end
      end
      if (cmd.walk_start) begin
        cur <= value_length; pending <= PW'(1); in_ext <= 1'b0; ext_cnt <= '0;
        walking <= 1'b1;
      end
      if (cmd.walk_step) begin
        cur <= cur - LW'(1);
        rd_valid <= 1'b1;
      end
      if (rd_valid && !w_fail && !w_pass) begin
        pending <= pend_n;
        if (in_ext) begin
          if (code[3:0] == 4'hF) ext_cnt <= ext_cnt + 5'd1;
          else begin in_ext <= 1'b0; ext_cnt <= '0; end
        end else if (code[1:0] == 2'b00 && code[3:2] == 2'b11) in_ext <= 1'b1;
      end
      if (cmd.walk_fail) begin
        first_fault <= FLT_VALUE; walking <= 1'b0;
      end
      if (cmd.walk_pass) begin
        walking <= 1'b0; wr_cnt <= '0;
        entries_done <= entries_done + 17'd1;
        phase <= (entries_done + 17'd1 >= entries_declared) ? PH_DONE : PH_INDEX;
      end
    end
  end

  // verdict either from a final walk or from the final beat itself
  always_comb begin
    fault = flt_next;
    if (sts.walk_done) begin
      if (w_fail) fault = FLT_VALUE;
      else if (entries_done + 17'd1 >= entries_declared) fault = FLT_NONE;
      else fault = FLT_TRUNC;
    end else if (fault == FLT_NONE &&
                 !(phase == PH_COUNT && byte_pos == 2'd3 && word == 32'd0)) begin
      fault = FLT_TRUNC;
    end
    valid_res = (fault == FLT_NONE);
    entry_total = count_ok ? entries_declared :
                  (first_fault == FLT_NONE && flt == FLT_NONE && phase == PH_COUNT &&
                   byte_pos == 2'd3) ? word[16:0] : 17'd0;
  end

  `ACV_ASSERT(a_no_take_walk, walking |-> !cmd.take, "byte taken during walk")
  `ACV_ASSERT(a_cur_bound, cur <= value_length || walking == 1'b0, "cursor past length")
  `ACV_ASSERT_RST(a_rst_clear, $past(rst) |-> first_fault == FLT_NONE, "fault after reset")
endmodule
`default_nettype wire

@@ src/acv_ctrl.sv @@
// ----------------------------------------------------------------------------
// acv_ctrl
// handshake and walk sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "annotation_container_validator_defines.svh"
module acv_ctrl
  import acv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_last,
  output logic      out_valid,
  input  wire logic out_ready,
  output acv_cmd_t  cmd,
  input  wire acv_sts_t sts,
  output logic      cap
);
  typedef enum logic [1:0] {S_IN, S_WALK, S_OUT} st_t;
  st_t state;
  logic walk_last;

  assign in_ready = (state == S_IN) && !(out_valid && !out_ready);
  always_comb begin
    cmd = '0;
    cmd.take = in_valid && in_ready;
    cmd.walk_start = cmd.take && sts.value_full;
    cmd.walk_step = (state == S_WALK) && !sts.walk_done;
    cmd.walk_pass = (state == S_WALK) && sts.walk_done && sts.walk_ok;
    cmd.walk_fail = (state == S_WALK) && sts.walk_done && !sts.walk_ok;
    cmd.clear = cap;
  end
  // verdict captured on the final byte unless a walk is pending
  assign cap = (in_valid && in_ready && in_last && !sts.value_full) ||
               ((state == S_WALK) && sts.walk_done && walk_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN; walk_last <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cap) out_valid <= 1'b1;
      unique case (state)
        S_IN: if (cmd.walk_start) begin
          state <= S_WALK; walk_last <= in_last;
        end
        S_WALK: if (sts.walk_done) state <= S_IN;
        default: state <= S_IN;
      endcase
    end
  end

  `ACV_ASSERT(a_walk_excl, (state == S_WALK) |-> !in_ready, "input open during walk")
  `ACV_ASSERT(a_cap_room, cap |-> !(out_valid && !out_ready), "verdict overwrites")
  `ACV_ASSERT(a_pass_fail, !(cmd.walk_pass && cmd.walk_fail), "walk pass and fail")
endmodule
`default_nettype wire

@@ src/annotation_container_validator.sv @@
// ----------------------------------------------------------------------------
// annotation_container_validator
// byte-stream checker for per-triangle annotation files, one verdict per file
// ----------------------------------------------------------------------------
// Header and field bytes are taken as they arrive. Value bytes are stored as they
// arrive; after the last value byte the input stalls while the value is walked
// backward from the buffer, one byte per walk step. The verdict appears the
// cycle after the final byte (or after the final walk) in an output register.
`timescale 1ns / 1ps
`default_nettype none
module annotation_container_validator
  import acv_pkg::*;
#(
  parameter int unsigned VALUE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // valid_res, fault[3:1], entry_total[20:4], pad
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [0:0] REG_TRI = 1'd0;
  localparam logic [0:0] REG_MAX = 1'd1;

  logic [31:0] triangle_limit;
  logic [7:0]  max_state;
  acv_cmd_t cmd;
  acv_sts_t sts;
  logic cap, v;
  logic [2:0] f;
  logic [16:0] et;

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_limit <= '0; max_state <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRI: triangle_limit <= cfg_data;
        REG_MAX: max_state <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  acv_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_last(s_axis_tlast), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd, .sts, .cap
  );

  acv_datapath #(.VALUE_BYTES(VALUE_BYTES)) u_dp (
    .clk, .rst, .cmd, .sts, .data_byte(s_axis_tdata),
    .triangle_limit, .max_state, .valid_res(v), .fault(f), .entry_total(et)
  );

  always_ff @(posedge clk) begin
    if (cap) m_axis_tdata <= {3'd0, et, f, v};
  end
endmodule
`default_nettype wire

@@ tb/annotation_container_validator_test.sv @@
// ----------------------------------------------------------------------------
// annotation_container_validator_test
// drives whole annotation files byte by byte (well-formed trees of random
// shape, mutated and truncated files, noise) and checks every verdict against
// a local model of the container and value-tree rules, with random idling on
// both stream sides and one long receiver hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module annotation_container_validator_test;
  import acv_pkg::*;

  localparam int VBYTES = 4096;

  typedef struct {
    logic        ok;
    fault_t      flt;
    logic [16:0] total;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // data_byte
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // valid_res, fault[3:1], entry_total[20:4], pad
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  annotation_container_validator dut (.*);

  always #2 clk = ~clk;

  // model state
  logic [31:0] tri_limit = 32'd0;
  logic [7:0]  max_leaf = 8'd2;
  phase_t      ph;
  logic [31:0] word_acc;
  int          word_pos;
  int unsigned seen;
  int unsigned n_declared, n_done;
  logic [31:0] last_idx;
  bit          have_idx, count_seen;
  int          val_len, val_pos;
  logic [7:0]  val_buf [VBYTES];
  fault_t      cur_fault;

  verdict_t    verdicts_due[$];
  int          n_errors = 0;
  bit          rx_no_idle = 0, tx_no_idle = 0;
  int          rx_hold = 0;
  byte unsigned file_q[$];
  byte unsigned nib_q[$];

  function automatic void add_file_byte(logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endfunction

  function automatic void add_nib(int v);
    nib_q.insert(nib_q.size(), 8'(v));
  endfunction

  function automatic int hexval(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit tree_ok(int len);
    int cur, open, code, nx, ext, st;
    cur = len;
    open = 1;
    while (open > 0) begin
      if (cur == 0) return 0;
      cur--;
      code = hexval(val_buf[cur]);
      if (code < 0) return 0;
      open--;
      if ((code & 3) != 0) begin
        open += (code & 3) + 1;
        if (open > VBYTES * 4) return 0;
        continue;
      end
      st = code >> 2;
      if ((code & 'hC) == 'hC) begin
        ext = 0;
        do begin
          if (cur == 0) return 0;
          cur--;
          nx = hexval(val_buf[cur]);
          if (nx < 0) return 0;
          if (nx == 'hF) begin
            ext++;
            if (ext > 16) return 0;
          end
        end while (nx == 'hF);
        st = nx + 15 * ext + 3;
      end
      if (st > max_leaf) return 0;
    end
    return cur == 0;
  endfunction

  function automatic void file_restart();
    ph = PH_MAGIC; word_acc = '0; word_pos = 0; seen = 0;
    n_declared = 0; n_done = 0; last_idx = '0; have_idx = 0;
    val_len = 0; val_pos = 0; cur_fault = FLT_NONE; count_seen = 0;
  endfunction

  function automatic void raise(fault_t f);
    if (cur_fault == FLT_NONE) cur_fault = f;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [31:0] w;
    logic [7:0] magic [4];
    magic = '{8'h44, 8'h4F, 8'h41, 8'h31};
    case (ph)
      PH_MAGIC: begin
        if (b != magic[word_pos]) begin
          raise(FLT_MAGIC);
          return;
        end
        word_pos = (word_pos + 1) % 4;
        if (word_pos == 0) ph = PH_COUNT;
        return;
      end
      PH_DONE: begin
        raise(FLT_TRUNC);
        return;
      end
      PH_VALUE: begin
        val_buf[val_pos] = b;
        val_pos++;
        if (val_pos >= val_len) begin
          if (!tree_ok(val_len)) begin
            raise(FLT_VALUE);
            return;
          end
          n_done++;
          ph = (n_done >= n_declared) ? PH_DONE : PH_INDEX;
        end
        return;
      end
      default: ;
    endcase
    word_acc = {word_acc[23:0], b};
    word_pos = (word_pos + 1) % 4;
    if (word_pos != 0) return;
    w = word_acc;
    word_acc = '0;
    if (ph == PH_COUNT) begin
      if (w > MaxEntries) begin
        raise(FLT_COUNT);
        return;
      end
      n_declared = w;
      count_seen = 1;
      ph = (w == 0) ? PH_DONE : PH_INDEX;
    end else if (ph == PH_INDEX) begin
      if (w >= tri_limit || (have_idx && w <= last_idx)) begin
        raise(FLT_INDEX);
        return;
      end
      last_idx = w;
      have_idx = 1;
      ph = PH_LENGTH;
    end else begin
      if (w == 0 || w > VBYTES) begin
        raise(FLT_LENGTH);
        return;
      end
      val_len = w;
      val_pos = 0;
      ph = PH_VALUE;
    end
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic last);
    verdict_t v;
    if (seen <= MaxFileBytes) seen++;
    if (seen > MaxFileBytes) raise(FLT_OVERSIZE);
    if (cur_fault == FLT_NONE) parse_byte(b);
    if (!last) return;
    if (ph != PH_DONE) raise(FLT_TRUNC);
    v.ok = (cur_fault == FLT_NONE);
    v.flt = cur_fault;
    v.total = count_seen ? n_declared[16:0] : '0;
    verdicts_due.insert(verdicts_due.size(), v);
    file_restart();
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(logic [7:0] b, logic last);
    int g;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_beat(b, last);
    g = pick_gap(tx_no_idle);
    if (g > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_beat(file_q[i], i == file_q.size() - 1);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle();
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == 1'b0) tri_limit = val;
    else max_leaf = val[7:0];
  endtask

  function automatic void put32(logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_file_byte(w[8*i +: 8]);
  endfunction

  // tree nibbles in walk order
  function automatic void grow_node(int depth);
    int code, k;
    if (depth >= 3 || $urandom_range(0, 1) == 0) begin
      code = 4 * $urandom_range(0, 3);
      add_nib(code);
      if (code == 'hC) begin
        k = ($urandom_range(0, 19) == 0) ? 17 : $urandom_range(0, 2);
        repeat (k) add_nib('hF);
        add_nib($urandom_range(0, 14));
      end
    end else begin
      code = 4 * $urandom_range(0, 3) + $urandom_range(1, 3);
      add_nib(code);
      repeat ((code & 3) + 1) grow_node(depth + 1);
    end
  endfunction

  function automatic void put_value(int big);
    int n;
    nib_q.delete();
    if (big) repeat (600) add_nib($urandom_range(0, 15));
    else grow_node(0);
    if ($urandom_range(0, 15) == 0) add_nib($urandom_range(0, 15));
    n = nib_q.size();
    put32(($urandom_range(0, 19) == 0) ? (($urandom_range(0, 1)) ? 0 : VBYTES + 1) : n);
    for (int i = n - 1; i >= 0; i--)
      add_file_byte(8'(nib_q[i] < 10 ? "0" + nib_q[i] : "A" + nib_q[i] - 10));
  endfunction

  function automatic void build_file(int big);
    int n, r;
    logic [31:0] idx;
    file_q.delete();
    n = $urandom_range(1, 4);
    put32(32'h444F4131);
    put32(($urandom_range(0, 19) == 0) ? n + 1 : n);
    idx = $urandom_range(0, 30);
    for (int e = 0; e < n; e++) begin
      if ($urandom_range(0, 29) == 0) idx = $urandom();
      put32(idx);
      put_value(big && e == 0);
      idx += ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 40);
    end
    r = $urandom_range(0, 99);
    if (r < 10) file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
    else if (r < 16) file_q = file_q[0 : $urandom_range(0, file_q.size() - 2)];
    else if (r < 20) repeat ($urandom_range(1, 3)) add_file_byte(8'($urandom_range(0, 255)));
    else if (r < 24) begin
      file_q.delete();
      repeat ($urandom_range(1, 12)) add_file_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_directed();
    write_reg(1'b0, 32'd1000);
    write_reg(1'b1, 32'd2);
    file_q = '{8'h44, 8'h58};
    send_file();
    file_q = '{8'h44, 8'h4F, 8'h41, 8'h31, 8'h00};
    send_file();
    file_q.delete(); put32(32'h444F4131); put32(0);
    send_file();
    file_q.delete(); put32(32'h444F4131); put32(100001);
    send_file();
    file_q.delete(); put32(32'h444F4131); put32(1); put32(999); put32(1);
    add_file_byte("8");
    send_file();
  endtask

  task automatic test_random(int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_file(0);
      sent += file_q.size();
      tx_no_idle = ($urandom_range(0, 7) == 0);
      rx_no_idle = ($urandom_range(0, 7) == 0);
      send_file();
    end
    tx_no_idle = 0;
    rx_no_idle = 0;
  endtask

  task automatic test_settings();
    write_reg(1'b0, 32'hFFFF_FFFF);
    write_reg(1'b1, 32'd255);
    test_random(150);
    write_reg(1'b0, 32'd0);
    write_reg(1'b1, 32'd0);
    test_random(75);
    write_reg(1'b0, 32'd5000);
    write_reg(1'b1, 32'd20);
    test_random(150);
    for (int p = 0; p < 3; p++) begin
      write_reg(1'b0, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(20, 200));
      write_reg(1'b1, $urandom_range(0, 255));
      test_random(125);
    end
  endtask

  task automatic test_backpressure();
    write_reg(1'b0, 32'd100000);
    write_reg(1'b1, 32'd3);
    rx_hold = 400;
    tx_no_idle = 1;
    repeat (6) begin
      build_file(0);
      send_file();
    end
    build_file(1);
    send_file();
    tx_no_idle = 0;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready <= (pick_gap(rx_no_idle) == 0);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict beat with none pending: %h", m_axis_tdata);
        n_errors++;
      end else begin
        v = verdicts_due.pop_front();
        if (m_axis_tdata[0] !== v.ok) begin
          $error("valid_res expected %0d got %0d", v.ok, m_axis_tdata[0]);
          n_errors++;
        end
        if (m_axis_tdata[3:1] !== v.flt) begin
          $error("fault expected %0d got %0d", v.flt, m_axis_tdata[3:1]);
          n_errors++;
        end
        if (m_axis_tdata[20:4] !== v.total) begin
          $error("entry_total expected %0d got %0d", v.total, m_axis_tdata[20:4]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    file_restart();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_settings();
    test_backpressure();
    settle();
    repeat (40) @(posedge clk);
    if (n_errors == 0 && verdicts_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+src
src/acv_pkg.sv
src/acv_datapath.sv
src/acv_ctrl.sv
src/annotation_container_validator.sv
tb/annotation_container_validator_test.sv
